// File: sv/tbl_pkg.sv
// ----------------------------------------------------------------------------
// tbl_pkg
// Shared constants for the token bucket limiter: register reset values,
// register indexes and the geometry of the iterative divide-by-1e9 unit.
// ----------------------------------------------------------------------------
package tbl_pkg;

  localparam int TimeW  = 64;
  localparam int TokW   = 32;
  localparam int CfgIdxW = 1;

  // register indexes on the configuration port
  localparam logic [CfgIdxW-1:0] RegCapacity = 1'b0;
  localparam logic [CfgIdxW-1:0] RegRate     = 1'b1;

  localparam logic [TokW-1:0] CapacityReset = 32'd1024;
  localparam logic [TokW-1:0] RateReset     = 32'd1000000;

  // divider: remainder below 1e9 fits 30 bits, four quotient bits a cycle
  localparam int RemW      = 30;
  localparam int DivSteps  = 4;
  localparam int DivCycles = TimeW / DivSteps;
  localparam int DivCntW   = $clog2(DivCycles);
  localparam logic [RemW:0] NsPerSec = 31'd1000000000;

endpackage

// File: sv/token_bucket_limiter.sv
// Each request word passes twice through the shared divider and twice
// through the shared 32x32 multiplier; no new request word is taken until
//   the sequencer has returned to idle from its grant step.
// The next request is taken while an earlier result still waits downstream.
// Reset: bucket capacity 1024, rate 1e6 tokens/s, bucket full, time base zero.
// ----------------------------------------------------------------------------
// token_bucket_limiter
// Token bucket admission control: refill from elapsed nanoseconds, saturate
// at capacity, then grant and debit the request if enough tokens are held.
// ----------------------------------------------------------------------------
module token_bucket_limiter (
  input  logic                             clk,
  input  logic                             rst,
  // configuration
  input  logic                             cfg_we,
  input  logic [tbl_pkg::CfgIdxW-1:0]      cfg_index,
  input  logic [tbl_pkg::TokW-1:0]         cfg_data,
  // request word
  input  logic                             in_valid,
  output logic                             in_stall,
  input  logic [tbl_pkg::TimeW-1:0]        now_time_ns,
  input  logic [tbl_pkg::TokW-1:0]         tokens_requested,
  // result word
  output logic                             out_valid,
  input  logic                             out_stall,
  output logic                             granted,
  output logic [tbl_pkg::TokW-1:0]         tokens_left
);

  // sequencer codes
  localparam logic [2:0] S_IDLE  = 3'd0;  // wait for a request word
  localparam logic [2:0] S_DIV1  = 3'd1;  // elapsed / 1e9 running
  localparam logic [2:0] S_MUL1  = 3'd2;  // frac * rate
  localparam logic [2:0] S_DIVS  = 3'd3;  // start second division, whole * rate
  localparam logic [2:0] S_DIV2  = 3'd4;  // (frac * rate) / 1e9 running
  localparam logic [2:0] S_SUM   = 3'd5;  // refill and saturate
  localparam logic [2:0] S_GRANT = 3'd6;  // compare, debit, emit result

  logic [2:0]                   state;

  // architectural state
  logic [tbl_pkg::TokW-1:0]     bucket_capacity;
  logic [tbl_pkg::TokW-1:0]     fill_rate;
  logic [tbl_pkg::TokW-1:0]     token_count;
  logic [tbl_pkg::TimeW-1:0]    last_refill_time;

  // per-request working registers
  logic [tbl_pkg::TokW-1:0]     req;
  logic                         whole_big;
  logic [tbl_pkg::TokW-1:0]     whole_lo;
  logic [tbl_pkg::RemW-1:0]     frac;
  logic [tbl_pkg::TimeW-1:0]    prod_frac;
  logic [tbl_pkg::TimeW-1:0]    prod_whole;
  logic [tbl_pkg::TokW-1:0]     fpart;

  // divider hookup
  logic                         div_start;
  logic [tbl_pkg::TimeW-1:0]    div_dividend;
  logic                         div_done;
  logic [tbl_pkg::TimeW-1:0]    div_quot;
  logic [tbl_pkg::RemW-1:0]     div_rem;

  // shared multiplier
  logic [tbl_pkg::TokW-1:0]     mul_a;
  logic [tbl_pkg::TimeW-1:0]    mul_p;

  // refill arithmetic
  logic [tbl_pkg::TokW-1:0]     room;
  logic [tbl_pkg::TimeW:0]      refill_sum;
  logic                         refill_full;

  logic                         in_accept;
  logic                         out_free;
  logic                         grant_ok;

  assign in_stall  = (state != S_IDLE);
  assign in_accept = in_valid && !in_stall;
  // output register can take a new word when empty or being drained
  assign out_free  = !out_valid || !out_stall;

  // The divider serves both divisions: elapsed time first, then the
  // fractional product. Elapsed wraps modulo 2^64 by plain subtraction.
  assign div_start    = in_accept || (state == S_DIVS);
  assign div_dividend = (state == S_DIVS) ? prod_frac : (now_time_ns - last_refill_time);

  tbl_div_unit u_div (
    .clk       (clk),
    .rst       (rst),
    .start     (div_start),
    .dividend  (div_dividend),
    .done      (div_done),
    .quotient  (div_quot),
    .remainder (div_rem)
  );

  // One 32x32 multiplier: fractional ns times rate, then whole seconds
  // (low 32 bits) times rate. The top quotient bits are handled as a flag.
  assign mul_a = (state == S_MUL1) ? tbl_pkg::TokW'(frac) : whole_lo;
  assign mul_p = mul_a * fill_rate;

  // Bucket never exceeds capacity, so room is a plain difference. The exact
  // sum whole*rate + fpart decides saturation; a whole-second count of 2^32
  // or more with a non-zero rate always fills the bucket.
  assign room        = bucket_capacity - token_count;
  assign refill_sum  = {1'b0, prod_whole} + (tbl_pkg::TimeW + 1)'(fpart);
  assign refill_full = (whole_big && (fill_rate != '0)) ||
                       (refill_sum >= (tbl_pkg::TimeW + 1)'(room));

  assign grant_ok = (token_count >= req);

  // sequencer and architectural state
  always_ff @(posedge clk) begin
    if (rst) begin
      state            <= S_IDLE;
      bucket_capacity  <= tbl_pkg::CapacityReset;
      fill_rate        <= tbl_pkg::RateReset;
      token_count      <= tbl_pkg::CapacityReset;
      last_refill_time <= '0;
      out_valid        <= 1'b0;
    end else begin
      // raise the result word on a grant step, drop it once taken downstream
      if ((state == S_GRANT) && out_free) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end

      // user writes configuration only in idle, unenforced; 0 capacity dropped
      if (cfg_we) begin
        case (cfg_index)
          tbl_pkg::RegCapacity: begin
            if (cfg_data != '0) begin
              bucket_capacity <= cfg_data;
              token_count     <= cfg_data;
            end
          end
          tbl_pkg::RegRate: begin
            fill_rate <= cfg_data;
          end
          default: ;
        endcase
      end

      case (state)
        S_IDLE: begin
          if (in_accept) begin
            last_refill_time <= now_time_ns;
            state            <= S_DIV1;
          end
        end
        S_DIV1: begin
          if (div_done) begin
            state <= S_MUL1;
          end
        end
        S_MUL1: begin
          state <= S_DIVS;
        end
        S_DIVS: begin
          state <= S_DIV2;
        end
        S_DIV2: begin
          if (div_done) begin
            state <= S_SUM;
          end
        end
        S_SUM: begin
          // refill: saturate at capacity
          if (refill_full) begin
            token_count <= bucket_capacity;
          end else begin
            token_count <= token_count + refill_sum[tbl_pkg::TokW-1:0];
          end
          state <= S_GRANT;
        end
        S_GRANT: begin
          // hold until the output register is free
          if (out_free) begin
            if (grant_ok) begin
              token_count <= token_count - req;
            end
            state <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  // payload registers, no reset needed
  always_ff @(posedge clk) begin
    if (in_accept) begin
      req <= tokens_requested;
    end
    if ((state == S_DIV1) && div_done) begin
      whole_big <= (div_quot[tbl_pkg::TimeW-1:tbl_pkg::TokW] != '0);
      whole_lo  <= div_quot[tbl_pkg::TokW-1:0];
      frac      <= div_rem;
    end
    if (state == S_MUL1) begin
      prod_frac <= mul_p;
    end
    if (state == S_DIVS) begin
      prod_whole <= mul_p;
    end
    if ((state == S_DIV2) && div_done) begin
      // (frac * rate) / 1e9 stays below 2^32
      fpart <= div_quot[tbl_pkg::TokW-1:0];
    end
    if ((state == S_GRANT) && out_free) begin
      granted     <= grant_ok;
      tokens_left <= grant_ok ? (token_count - req) : token_count;
    end
  end

endmodule

// File: sv/tbl_div_unit.sv
// ----------------------------------------------------------------------------
// tbl_div_unit
// Iterative 64-bit divide by one second in nanoseconds: restoring division,
// four quotient bits per cycle, done pulse after the last step.
// ----------------------------------------------------------------------------
module tbl_div_unit (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              start,
  input  logic [tbl_pkg::TimeW-1:0]         dividend,
  output logic                              done,
  output logic [tbl_pkg::TimeW-1:0]         quotient,
  output logic [tbl_pkg::RemW-1:0]          remainder
);

  logic                              active;
  logic [tbl_pkg::DivCntW-1:0]       cnt;
  logic [tbl_pkg::TimeW-1:0]         work;
  logic [tbl_pkg::TimeW-1:0]         work_next;
  logic [tbl_pkg::RemW-1:0]          rem;
  logic [tbl_pkg::RemW-1:0]          rem_next;
  logic [tbl_pkg::RemW-1:0]          r;
  logic [tbl_pkg::RemW:0]            t;
  logic [tbl_pkg::DivSteps-1:0]      q;

  // four restoring steps on the 31-bit partial remainder
  always_comb begin
    r = rem;
    q = '0;
    t = '0;
    for (int i = 0; i < tbl_pkg::DivSteps; i++) begin
      t = {r, work[tbl_pkg::TimeW-1-i]};
      if (t >= tbl_pkg::NsPerSec) begin
        t = t - tbl_pkg::NsPerSec;
        q[tbl_pkg::DivSteps-1-i] = 1'b1;
      end
      r = t[tbl_pkg::RemW-1:0];
    end
    rem_next  = r;
    work_next = {work[tbl_pkg::TimeW-tbl_pkg::DivSteps-1:0], q};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      active <= 1'b0;
      done   <= 1'b0;
      cnt    <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        active <= 1'b1;
        cnt    <= '0;
      end else if (active) begin
        cnt <= cnt + 1'b1;
        if (cnt == tbl_pkg::DivCntW'(tbl_pkg::DivCycles - 1)) begin
          active <= 1'b0;
          done   <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      work <= dividend;
      rem  <= '0;
    end else if (active) begin
      work <= work_next;
      rem  <= rem_next;
    end
  end

  assign quotient  = work;
  assign remainder = rem;

endmodule

// File: dv/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for token_bucket_limiter. A cycle-free predictor of the
// bucket state works out each grant and level as request words are taken;
// a checker compares every result word with the oldest prediction. Directed
// tests cover empty/full buckets, wrapping timestamps and register extremes,
// then random traffic runs under three sender/receiver idling patterns.
// ----------------------------------------------------------------------------
module tb_top;

  localparam longint unsigned NsPerSecond = 64'd1_000_000_000;
  localparam int              DrainCycles = 2 * 38;   // margin after the last result word
  localparam longint unsigned RunLimitNs  = 64'd5_000_000;

  typedef struct packed {
    logic                     granted;
    logic [tbl_pkg::TokW-1:0] left;
  } bucket_verdict_t;

  logic                          clk;
  logic                          rst;
  logic                          cfg_we;
  logic [tbl_pkg::CfgIdxW-1:0]   cfg_index;
  logic [tbl_pkg::TokW-1:0]      cfg_data;
  logic                          in_valid;
  logic                          in_stall;
  logic [tbl_pkg::TimeW-1:0]     now_time_ns;
  logic [tbl_pkg::TokW-1:0]      tokens_requested;
  logic                          out_valid;
  logic                          out_stall = 1'b0;
  logic                          granted;
  logic [tbl_pkg::TokW-1:0]      tokens_left;

  // predictor copy of the bucket
  logic [tbl_pkg::TokW-1:0]      model_capacity;
  logic [tbl_pkg::TokW-1:0]      model_rate;
  logic [tbl_pkg::TokW-1:0]      model_tokens;
  logic [tbl_pkg::TimeW-1:0]     model_last_ns;

  bucket_verdict_t      verdict_q[$];
  int unsigned          send_idle_pct;
  int unsigned          recv_idle_pct;
  int unsigned          mismatch_count;
  int unsigned          requests_sent;
  int unsigned          grants_seen;
  int unsigned          refusals_seen;
  int unsigned          reg_writes;

  token_bucket_limiter DUT (
    .clk              (clk),
    .rst              (rst),
    .cfg_we           (cfg_we),
    .cfg_index        (cfg_index),
    .cfg_data         (cfg_data),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .now_time_ns      (now_time_ns),
    .tokens_requested (tokens_requested),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .granted          (granted),
    .tokens_left      (tokens_left)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  initial begin
    #(RunLimitNs);
    $display("Run limit reached with %0d results outstanding", verdict_q.size());
    $display("*** FAILED ***");
    $finish;
  end

  // Refill from elapsed time, clip at capacity, then grant and debit.
  // A 128-bit sum makes the overflowing whole-second product saturate too.
  function automatic void predict_admission(input logic [tbl_pkg::TimeW-1:0] now_ns,
                                            input logic [tbl_pkg::TokW-1:0]  want);
    logic [tbl_pkg::TimeW-1:0] elapsed;
    logic [tbl_pkg::TimeW-1:0] whole;
    logic [tbl_pkg::TimeW-1:0] frac;
    logic [tbl_pkg::TimeW-1:0] fpart;
    logic [127:0]              added;
    logic [tbl_pkg::TokW-1:0]  room;
    bucket_verdict_t           v;
    elapsed = now_ns - model_last_ns;
    whole   = elapsed / NsPerSecond;
    frac    = elapsed % NsPerSecond;
    if (model_tokens > model_capacity) model_tokens = model_capacity;
    room    = model_capacity - model_tokens;
    fpart   = (frac * 64'(model_rate)) / NsPerSecond;
    added   = 128'(whole) * 128'(model_rate) + 128'(fpart);
    if (added >= 128'(room)) begin
      model_tokens = model_capacity;
    end else begin
      model_tokens = model_tokens + added[tbl_pkg::TokW-1:0];
    end
    model_last_ns = now_ns;
    v.granted = (model_tokens >= want);
    if (v.granted) model_tokens = model_tokens - want;
    v.left = model_tokens;
    verdict_q.push_back(v);
  endfunction

  // Present one request word, hold it through stalls, predict on acceptance.
  task automatic send_request(input logic [tbl_pkg::TimeW-1:0] now_ns,
                              input logic [tbl_pkg::TokW-1:0] want);
    if ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < send_idle_pct);
    end
    in_valid         <= 1'b1;
    now_time_ns      <= now_ns;
    tokens_requested <= want;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    predict_admission(now_ns, want);
    requests_sent++;
  endtask

  // Drop valid and hold off until every predicted result has come back.
  task automatic drain_results();
    in_valid <= 1'b0;
    do @(posedge clk); while (verdict_q.size() != 0);
  endtask

  task automatic write_register(input logic [tbl_pkg::CfgIdxW-1:0] idx,
                                input logic [tbl_pkg::TokW-1:0] val);
    drain_results();
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    if (idx == tbl_pkg::RegCapacity) begin
      // a zero capacity is ignored; otherwise the bucket refills to full
      if (val != '0) begin
        model_capacity = val;
        model_tokens   = val;
      end
    end else if (idx == tbl_pkg::RegRate) begin
      model_rate = val;
    end
    reg_writes++;
  endtask

  // Reset values: 1024 tokens at 1 token/us, time base zero.
  task automatic test_empty_and_refill();
    send_request(64'd0, 32'd0);               // zero request only refills
    send_request(64'd0, 32'd1024);            // empty the bucket
    send_request(64'd0, 32'd1);               // refused, nothing elapsed
    send_request(64'd500, 32'd1);             // fraction below one token is lost
    send_request(64'd2500, 32'd2);            // exactly two tokens back
    send_request(64'd1_000_002_500, 32'd0);   // a whole second saturates
  endtask

  task automatic test_field_extremes();
    send_request('1, '1);                     // all ones: full bucket, refused
    send_request(64'h5555_5555_5555_5555, 32'd1);   // time goes backwards
    send_request(64'hAAAA_AAAA_AAAA_AAAA, 32'hAAAA_AAAA);
    send_request(64'd0, 32'h5555_5555);       // back to zero, wraps again
  endtask

  task automatic test_capacity_writes();
    logic [tbl_pkg::TimeW-1:0] t;
    t = model_last_ns;
    send_request(t, 32'd100);
    write_register(tbl_pkg::RegCapacity, '0); // ignored: level must not move
    send_request(t, 32'd0);
    write_register(tbl_pkg::RegCapacity, 32'd1);
    send_request(t, 32'd1);
    send_request(t, 32'd1);
    write_register(tbl_pkg::RegCapacity, '1);
    send_request(t, '1);                      // take the whole bucket
    send_request(t + NsPerSecond, 32'd0);     // one second at 1e6 tokens/s
  endtask

  task automatic test_rate_extremes();
    logic [tbl_pkg::TimeW-1:0] t;
    write_register(tbl_pkg::RegRate, '0);
    t = model_last_ns + 64'd1_000_000_000_000;
    send_request(t, 32'd5);                   // no refill at rate zero
    write_register(tbl_pkg::RegRate, '1);
    t = model_last_ns;
    send_request(t, 32'h8000_0000);
    send_request(t + 64'd1, 32'd0);           // one ns yields four tokens
    send_request(t + 64'd3, 32'h7FFF_0000);
    send_request(t + 64'h8000_0000_0000_0000, 32'd0);   // product overflows 64 bits
  endtask

  task automatic test_random_traffic(input logic [tbl_pkg::TokW-1:0] cap,
                                     input logic [tbl_pkg::TokW-1:0] rate,
                                     input int unsigned s_pct, input int unsigned r_pct,
                                     input int unsigned n_req);
    logic [tbl_pkg::TimeW-1:0] t;
    logic [tbl_pkg::TokW-1:0]  want;
    logic [tbl_pkg::TokW-1:0]  level;
    int unsigned               pick;
    write_register(tbl_pkg::RegCapacity, cap);
    write_register(tbl_pkg::RegRate, rate);
    send_idle_pct = s_pct;
    recv_idle_pct = r_pct;
    t = model_last_ns;
    for (int i = 0; i < n_req; i++) begin
      // halfway, hold the sender off until the pipe is empty
      if (i == n_req / 2) drain_results();
      pick = $urandom_range(99);
      if (pick < 45) begin
        t = t + $urandom_range(5000);
      end else if (pick < 75) begin
        t = t + $urandom_range(2_000_000);
      end else if (pick < 88) begin
        t = t + 64'($urandom_range(3)) * NsPerSecond + $urandom_range(999_999_999);
      end else if (pick < 94) begin
        t = t + {$urandom, $urandom};
      end else begin
        t = {$urandom, $urandom};
      end
      level = model_tokens;
      pick  = $urandom_range(99);
      if (pick < 12) begin
        want = '0;
      end else if (pick < 55) begin
        want = $urandom_range(level);
      end else if (pick < 75) begin
        want = level + $urandom_range(1, 20);
      end else if (pick < 90) begin
        want = $urandom_range(model_capacity);
      end else if (pick < 97) begin
        want = $urandom;
      end else begin
        want = '1;
      end
      send_request(t, want);
    end
  endtask

  // Receiver: stall at random, and check each result word taken.
  always @(posedge clk) begin : result_check
    bucket_verdict_t due;
    if (rst) begin
      out_stall <= 1'b0;
    end else begin
      out_stall <= ($urandom_range(99) < recv_idle_pct);
    end
    if (!rst && out_valid && !out_stall) begin
      if (verdict_q.size() == 0) begin
        $error("result word with no request outstanding: granted %0d, tokens_left %0d",
               granted, tokens_left);
        mismatch_count++;
      end else begin
        due = verdict_q.pop_front();
        if (granted !== due.granted) begin
          $error("granted: expected %0d, got %0d", due.granted, granted);
          mismatch_count++;
        end
        if (tokens_left !== due.left) begin
          $error("tokens_left: expected %0d, got %0d", due.left, tokens_left);
          mismatch_count++;
        end
        if (granted) grants_seen++;
        else refusals_seen++;
      end
    end
  end

  initial begin
    rst              <= 1'b1;
    cfg_we           <= 1'b0;
    cfg_index        <= tbl_pkg::RegCapacity;
    cfg_data         <= '0;
    in_valid         <= 1'b0;
    now_time_ns      <= '0;
    tokens_requested <= '0;
    model_capacity   = tbl_pkg::CapacityReset;
    model_rate       = tbl_pkg::RateReset;
    model_tokens     = tbl_pkg::CapacityReset;
    model_last_ns    = '0;
    mismatch_count   = 0;
    requests_sent    = 0;
    grants_seen      = 0;
    refusals_seen    = 0;
    reg_writes       = 0;
    send_idle_pct    = 30;
    recv_idle_pct    = 47;
    repeat (3) @(posedge clk);
    rst <= 1'b0;

    test_empty_and_refill();
    test_field_extremes();
    test_capacity_writes();
    test_rate_extremes();
    test_random_traffic(32'd1000, 32'd1_000_000, 30, 47, 285);
    test_random_traffic(32'd100_000, 32'd3_000_000_000, 47, 30, 285);
    test_random_traffic('1, 32'd7, 0, 0, 285);

    drain_results();
    repeat (DrainCycles) @(posedge clk);
    $display("Covered %0d requests (%0d granted, %0d refused) over %0d register writes,",
             requests_sent, grants_seen, refusals_seen, reg_writes);
    $display("with wrapping timestamps, saturating refills and three idling patterns.");
    if (mismatch_count == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
